FILE: rtl/rrbmr_pkg.sv
// rrbmr_pkg: shared types and constants of the rom/ram bank mapper
// used by rom_ram_bank_mapper_with_rtc_regs; depends on nothing
`default_nettype none

package rrbmr_pkg;

   typedef enum logic [1:0] {
      OP_ROM_READ   = 2'd0,
      OP_CTRL_WRITE = 2'd1,
      OP_RAM_READ   = 2'd2,
      OP_RAM_WRITE  = 2'd3
   } op_type;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 21;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_ROM_BANK_COUNT   = 2'd0;
   localparam csr_index_type CSR_ROM_ADDRESS_MASK = 2'd1;
   localparam csr_index_type CSR_RAM_BANK_COUNT   = 2'd2;
   localparam csr_index_type CSR_RAM_ADDRESS_MASK = 2'd3;

   // control write regions, by address[15:13]
   typedef logic [2:0] region_type;
   localparam region_type REGION_ENABLE   = 3'b000;
   localparam region_type REGION_ROM_BANK = 3'b001;
   localparam region_type REGION_SELECT   = 3'b010;

   // rtc register selection codes
   typedef logic [3:0] sel_type;
   localparam sel_type SEL_RTC_SEC      = 4'h8;
   localparam sel_type SEL_RTC_MIN      = 4'h9;
   localparam sel_type SEL_RTC_HOUR     = 4'hA;
   localparam sel_type SEL_RTC_DAY_LOW  = 4'hB;
   localparam sel_type SEL_RTC_DAY_HIGH = 4'hC;

   localparam logic [3:0]  ENABLE_KEY       = 4'hA;
   localparam logic [7:0]  SECONDS_LIMIT    = 8'd60;
   localparam logic [7:0]  HOURS_LIMIT      = 8'd24;
   localparam logic [7:0]  DAY_HIGH_MASK    = 8'hC1;
   localparam logic [7:0]  READ_DISABLED    = 8'hFF;
   localparam logic [12:0] RAM_OFFSET_MASK  = 13'h1FFF;
   localparam logic [13:0] ROM_OFFSET_MASK  = 14'h3FFF;

   // reset values of the configuration registers
   localparam logic [7:0]  RESET_ROM_BANK_COUNT   = 8'd2;
   localparam logic [20:0] RESET_ROM_ADDRESS_MASK = 21'd32767;
   localparam logic [2:0]  RESET_RAM_BANK_COUNT   = 3'd0;
   localparam logic [14:0] RESET_RAM_ADDRESS_MASK = 15'd0;

endpackage

`default_nettype wire

FILE: rtl/rrbmr_ram.sv
// rrbmr_ram: generic single-clock ram, one write port and one registered read port
// standalone, no package needed
`default_nettype none

module rrbmr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rom_ram_bank_mapper_with_rtc_regs.sv
// rom_ram_bank_mapper_with_rtc_regs: cartridge bank controller with rtc registers
// depends on rrbmr_pkg and rrbmr_ram
//
//   channel  | direction | handshake           | payload
//   req_     | in        | req_valid/req_stall | operation, address, write_data
//   rsp_     | out       | rsp_valid/rsp_stall | read_data, rom_address
//   csr_     | in        | csr_valid/csr_ready | index, write_data
//
// one item per cycle while req_stall is low; a result passes through the decode stage,
// which holds the ram read, and then the output register before it is offered
// mapper and rtc state updates and ram writes take effect at the edge that accepts the item
// reset restores the reset values of control state and configuration; ram contents are not cleared
// req_stall rises only when both stages are full and rsp_stall is high
`default_nettype none

module rom_ram_bank_mapper_with_rtc_regs #(
   parameter int unsigned RAM_DEPTH      = 32768,
   parameter int unsigned ROM_ADDR_WIDTH = 21
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire rrbmr_pkg::op_type           req_operation,
   input  wire logic [15:0]                 req_address,
   input  wire logic [7:0]                  req_write_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_read_data,
   output logic [ROM_ADDR_WIDTH-1:0]        rsp_rom_address,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire rrbmr_pkg::csr_index_type    csr_index,
   input  wire logic [rrbmr_pkg::CSR_DATA_W-1:0] csr_write_data
);

   import rrbmr_pkg::*;

   localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

   // configuration
   logic [7:0]  rom_bank_count_ff;
   logic [20:0] rom_address_mask_ff;
   logic [2:0]  ram_bank_count_ff;
   logic [14:0] ram_address_mask_ff;

   // mapper and rtc state
   logic [6:0] rom_bank_ff, rom_bank_in;
   sel_type    select_ff, select_in;
   logic       enabled_ff, enabled_in;
   logic [5:0] rtc_sec_ff, rtc_sec_in;
   logic [5:0] rtc_min_ff, rtc_min_in;
   logic [4:0] rtc_hour_ff, rtc_hour_in;
   logic [7:0] rtc_day_low_ff, rtc_day_low_in;
   logic [7:0] rtc_day_high_ff, rtc_day_high_in;

   // decode stage and output register
   logic                      s1_valid_ff;
   logic                      s1_use_ram_ff, s1_use_ram_in;
   logic [7:0]                s1_read_data_ff, s1_read_data_in;
   logic [ROM_ADDR_WIDTH-1:0] s1_rom_address_ff, s1_rom_address_in;
   logic                      out_valid_ff;
   logic [7:0]                out_read_data_ff, out_read_data_in;
   logic [ROM_ADDR_WIDTH-1:0] out_rom_address_ff;

   logic        req_accept;
   logic        s1_move;
   logic        rtc_selected;
   logic        ram_access;
   logic [7:0]  rtc_value;
   logic [6:0]  bank_mask;
   logic [6:0]  bank_req;
   logic [14:0] ram_index;
   logic [20:0] rom_map;
   logic        ram_wr_en;
   logic        ram_rd_en;
   logic [7:0]  ram_rd_data;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rtc_selected = (select_ff >= SEL_RTC_SEC) && (select_ff <= SEL_RTC_DAY_HIGH);
   assign ram_access   = enabled_ff && !rtc_selected && (ram_bank_count_ff != 3'd0);

   assign ram_index = ({select_ff[1:0], req_address[12:0] & RAM_OFFSET_MASK})
                      & ram_address_mask_ff;

   assign ram_wr_en = req_accept && (req_operation == OP_RAM_WRITE) && ram_access;
   assign ram_rd_en = req_accept && (req_operation == OP_RAM_READ);

   // only the low seven bits of count - 1 reach the bank number
   assign bank_mask = rom_bank_count_ff[6:0] - 7'd1;
   assign bank_req  = req_write_data[6:0];

   always_comb begin
      case (select_ff)
         SEL_RTC_SEC:     rtc_value = {2'd0, rtc_sec_ff};
         SEL_RTC_MIN:     rtc_value = {2'd0, rtc_min_ff};
         SEL_RTC_HOUR:    rtc_value = {3'd0, rtc_hour_ff};
         SEL_RTC_DAY_LOW: rtc_value = rtc_day_low_ff;
         default:         rtc_value = rtc_day_high_ff;
      endcase
   end

   // rom address: bank 0 below 0x4000 and at 0x8000 and above
   always_comb begin
      rom_map = {7'd0, req_address[13:0] & ROM_OFFSET_MASK};
      if (req_address[15:14] == 2'b01) begin
         rom_map = {rom_bank_ff, req_address[13:0]};
      end
      rom_map = rom_map & rom_address_mask_ff;
   end

   // next state and decode stage inputs
   always_comb begin
      rom_bank_in       = rom_bank_ff;
      select_in         = select_ff;
      enabled_in        = enabled_ff;
      rtc_sec_in        = rtc_sec_ff;
      rtc_min_in        = rtc_min_ff;
      rtc_hour_in       = rtc_hour_ff;
      rtc_day_low_in    = rtc_day_low_ff;
      rtc_day_high_in   = rtc_day_high_ff;
      s1_use_ram_in     = 1'b0;
      s1_read_data_in   = 8'd0;
      s1_rom_address_in = '0;
      case (req_operation)
         OP_ROM_READ: begin
            s1_rom_address_in = rom_map[ROM_ADDR_WIDTH-1:0];
         end
         OP_CTRL_WRITE: begin
            case (region_type'(req_address[15:13]))
               REGION_ENABLE: begin
                  enabled_in = (req_write_data[3:0] == ENABLE_KEY);
               end
               REGION_ROM_BANK: begin
                  if (bank_req == 7'd0) begin
                     rom_bank_in = 7'd1;
                  end else begin
                     rom_bank_in = bank_req & bank_mask;
                  end
               end
               REGION_SELECT: begin
                  if (req_write_data >= {4'd0, SEL_RTC_SEC}
                        && req_write_data <= {4'd0, SEL_RTC_DAY_HIGH}) begin
                     select_in = req_write_data[3:0];
                  end else begin
                     select_in = {2'd0, req_write_data[1:0]};
                  end
               end
               default: begin
               end
            endcase
         end
         OP_RAM_READ: begin
            if (!enabled_ff) begin
               s1_read_data_in = READ_DISABLED;
            end else if (rtc_selected) begin
               s1_read_data_in = rtc_value;
            end else if (ram_bank_count_ff == 3'd0) begin
               s1_read_data_in = READ_DISABLED;
            end else begin
               s1_use_ram_in = 1'b1;
            end
         end
         default: begin
            if (enabled_ff && rtc_selected) begin
               case (select_ff)
                  SEL_RTC_SEC: begin
                     if (req_write_data < SECONDS_LIMIT) begin
                        rtc_sec_in = req_write_data[5:0];
                     end
                  end
                  SEL_RTC_MIN: begin
                     if (req_write_data < SECONDS_LIMIT) begin
                        rtc_min_in = req_write_data[5:0];
                     end
                  end
                  SEL_RTC_HOUR: begin
                     if (req_write_data < HOURS_LIMIT) begin
                        rtc_hour_in = req_write_data[4:0];
                     end
                  end
                  SEL_RTC_DAY_LOW: rtc_day_low_in = req_write_data;
                  default:         rtc_day_high_in = req_write_data & DAY_HIGH_MASK;
               endcase
            end
         end
      endcase
   end

   assign out_read_data_in = s1_use_ram_ff ? ram_rd_data : s1_read_data_ff;

   rrbmr_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_index[RAM_AW-1:0]),
      .wr_data (req_write_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_index[RAM_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_count_ff   <= RESET_ROM_BANK_COUNT;
         rom_address_mask_ff <= RESET_ROM_ADDRESS_MASK;
         ram_bank_count_ff   <= RESET_RAM_BANK_COUNT;
         ram_address_mask_ff <= RESET_RAM_ADDRESS_MASK;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROM_BANK_COUNT:   rom_bank_count_ff   <= csr_write_data[7:0];
            CSR_ROM_ADDRESS_MASK: rom_address_mask_ff <= csr_write_data[20:0];
            CSR_RAM_BANK_COUNT:   ram_bank_count_ff   <= csr_write_data[2:0];
            CSR_RAM_ADDRESS_MASK: ram_address_mask_ff <= csr_write_data[14:0];
            default: begin
            end
         endcase
      end
   end

   // mapper state, updated when an item is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff     <= 7'd1;
         select_ff       <= '0;
         enabled_ff      <= 1'b0;
         rtc_sec_ff      <= '0;
         rtc_min_ff      <= '0;
         rtc_hour_ff     <= '0;
         rtc_day_low_ff  <= '0;
         rtc_day_high_ff <= '0;
      end else if (req_accept) begin
         rom_bank_ff     <= rom_bank_in;
         select_ff       <= select_in;
         enabled_ff      <= enabled_in;
         rtc_sec_ff      <= rtc_sec_in;
         rtc_min_ff      <= rtc_min_in;
         rtc_hour_ff     <= rtc_hour_in;
         rtc_day_low_ff  <= rtc_day_low_in;
         rtc_day_high_ff <= rtc_day_high_in;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_use_ram_ff     <= s1_use_ram_in;
         s1_read_data_ff   <= s1_read_data_in;
         s1_rom_address_ff <= s1_rom_address_in;
      end
      if (s1_move) begin
         out_read_data_ff   <= out_read_data_in;
         out_rom_address_ff <= s1_rom_address_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = out_read_data_ff;
   assign rsp_rom_address = out_rom_address_ff;

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item did not reach the decode stage");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_rom_address_ff)
                                      && $stable(s1_read_data_ff)))
      else $error("decode stage changed while blocked");

   a_ram_item_clean: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_use_ram_ff) |-> (s1_read_data_ff == 8'd0
                                          && s1_rom_address_ff == '0))
      else $error("ram read item carries other payload");

   a_rtc_ranges: assert property (@(posedge clock) disable iff (reset)
      (rtc_sec_ff < 6'd60) && (rtc_min_ff < 6'd60) && (rtc_hour_ff < 5'd24))
      else $error("rtc time register out of range");

   a_day_high_mask: assert property (@(posedge clock) disable iff (reset)
      (rtc_day_high_ff & ~DAY_HIGH_MASK) == 8'd0)
      else $error("rtc day-high holds masked bits");

endmodule

`default_nettype wire

FILE: sim/rom_ram_bank_mapper_with_rtc_regs_test.sv
`timescale 1ns / 100ps
// rom_ram_bank_mapper_with_rtc_regs_test: self-checking bench for the cartridge bank mapper
// drives bus accesses and register writes, predicts every result in order and compares
// depends on rrbmr_pkg and rom_ram_bank_mapper_with_rtc_regs

module rom_ram_bank_mapper_with_rtc_regs_test;
   import rrbmr_pkg::*;

   localparam int unsigned RAM_WORDS = 32768;
   localparam int          N_DIRECTED = 31;
   localparam int          N_PHASES = 9;
   localparam int          ITEMS_PER_PHASE = 100;
   localparam int          PRESSURE_PHASE = 8;
   localparam int          HOLD_CYCLES = 40;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      op_type        op;
      csr_index_type reg_idx;
      logic [15:0]   addr;
      logic [20:0]   data;
      logic          pinned;
      logic [7:0]    exp_rd;
      logic [20:0]   exp_ra;
   } stim_row_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [20:0] rom_address;
   } bus_result_type;

   typedef struct packed {
      logic [7:0]  rom_banks;
      logic [20:0] rom_mask;
      logic [2:0]  ram_banks;
      logic [14:0] ram_mask;
   } cfg_set_type;

   // extremes first, then the masked, zero-count and odd-mask settings
   localparam cfg_set_type PHASE_CFG [N_PHASES] = '{
      '{8'd128, 21'h1FFFFF, 3'd4, 15'h7FFF},
      '{8'd2,   21'h007FFF, 3'd1, 15'h1FFF},
      '{8'd0,   21'h1FFFFF, 3'd7, 15'h7FFF},
      '{8'd16,  21'h03FFFF, 3'd2, 15'h3FFF},
      '{8'd64,  21'h000000, 3'd0, 15'h0000},
      '{8'd32,  21'h0FFFFF, 3'd5, 15'h07FF},
      '{8'd8,   21'h01FFFF, 3'd6, 15'h2AAA},
      '{8'd4,   21'h1FFFFF, 3'd3, 15'h7FFF},
      '{8'd128, 21'h1FFFFF, 3'd4, 15'h7FFF}
   };

   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // reset configuration: two rom banks, no ram
      '{ROW_ITEM, OP_ROM_READ,   CSR_ROM_BANK_COUNT, 16'h7FFF, 21'h00, 1'b1, 8'h00, 21'h7FFF},
      '{ROW_ITEM, OP_ROM_READ,   CSR_ROM_BANK_COUNT, 16'hFFFF, 21'h00, 1'b1, 8'h00, 21'h3FFF},
      '{ROW_ITEM, OP_RAM_READ,   CSR_ROM_BANK_COUNT, 16'hA000, 21'h00, 1'b1, 8'hFF, 21'h0},
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h0000, 21'h0A, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_READ,   CSR_ROM_BANK_COUNT, 16'hBFFF, 21'h00, 1'b1, 8'hFF, 21'h0},
      '{ROW_ITEM, OP_RAM_WRITE,  CSR_ROM_BANK_COUNT, 16'hA000, 21'h55, 1'b1, 8'h00, 21'h0},
      '{ROW_CSR,  OP_ROM_READ,   CSR_ROM_BANK_COUNT,   16'h0, 21'd128,    1'b0, 8'h0, 21'h0},
      '{ROW_CSR,  OP_ROM_READ,   CSR_ROM_ADDRESS_MASK, 16'h0, 21'h1FFFFF, 1'b0, 8'h0, 21'h0},
      '{ROW_CSR,  OP_ROM_READ,   CSR_RAM_BANK_COUNT,   16'h0, 21'd4,      1'b0, 8'h0, 21'h0},
      '{ROW_CSR,  OP_ROM_READ,   CSR_RAM_ADDRESS_MASK, 16'h0, 21'h7FFF,   1'b0, 8'h0, 21'h0},
      // bank zero turns into one, then the widest bank
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h2000, 21'h00, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_ROM_READ,   CSR_ROM_BANK_COUNT, 16'h4000, 21'h00, 1'b0, 8'h00, 21'h0},
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h3FFF, 21'hFF, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_ROM_READ,   CSR_ROM_BANK_COUNT, 16'h7FFF, 21'h00, 1'b1, 8'h00, 21'h1FFFFF},
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h5FFF, 21'h07, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_WRITE,  CSR_ROM_BANK_COUNT, 16'hBFFF, 21'hA5, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_READ,   CSR_ROM_BANK_COUNT, 16'hFFFF, 21'h00, 1'b0, 8'h00, 21'h0},
      // rtc seconds: 59 sticks, 60 is dropped
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h4000, 21'h08, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_WRITE,  CSR_ROM_BANK_COUNT, 16'h0000, 21'h3B, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_WRITE,  CSR_ROM_BANK_COUNT, 16'h1234, 21'h3C, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_READ,   CSR_ROM_BANK_COUNT, 16'hA000, 21'h00, 1'b0, 8'h00, 21'h0},
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h4000, 21'h0C, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_WRITE,  CSR_ROM_BANK_COUNT, 16'hA000, 21'hFF, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_READ,   CSR_ROM_BANK_COUNT, 16'hA000, 21'h00, 1'b0, 8'h00, 21'h0},
      // latch range and high addresses do nothing
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h6000, 21'h00, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h8000, 21'h00, 1'b1, 8'h00, 21'h0},
      '{ROW_CSR,  OP_ROM_READ,   CSR_ROM_BANK_COUNT,   16'h0, 21'd4,      1'b0, 8'h0, 21'h0},
      // bank masked down to zero stays zero
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h2000, 21'h04, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_ROM_READ,   CSR_ROM_BANK_COUNT, 16'h4000, 21'h00, 1'b0, 8'h00, 21'h0},
      '{ROW_ITEM, OP_CTRL_WRITE, CSR_ROM_BANK_COUNT, 16'h1FFF, 21'hFB, 1'b1, 8'h00, 21'h0},
      '{ROW_ITEM, OP_RAM_READ,   CSR_ROM_BANK_COUNT, 16'hA000, 21'h00, 1'b1, 8'hFF, 21'h0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   op_type                req_operation = OP_ROM_READ;
   logic [15:0]           req_address = '0;
   logic [7:0]            req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_read_data;
   logic [20:0]           rsp_rom_address;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_ROM_BANK_COUNT;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // expectation typed into the table travels with its item
   logic           pin_valid = 1'b0;
   bus_result_type pin_result = '0;

   // mapper shadow state
   logic [7:0]  cfg_rom_banks;
   logic [20:0] cfg_rom_mask;
   logic [2:0]  cfg_ram_banks;
   logic [14:0] cfg_ram_mask;
   logic [6:0]  rom_bank;
   logic [3:0]  sel;
   logic        ram_enabled;
   logic [7:0]  rtc_sec, rtc_min, rtc_hour, rtc_day_low, rtc_day_high;
   logic [7:0]  ram_shadow [RAM_WORDS];
   bit          ram_known [RAM_WORDS];

   bus_result_type expected_results [$];
   logic [15:0]    ram_addr_history [$];

   bit sender_eager = 1'b0;
   bit receiver_calm = 1'b0;
   int hold_len = 0;
   int items_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int mismatch_count = 0;

   rom_ram_bank_mapper_with_rtc_regs #(
      .RAM_DEPTH      (RAM_WORDS),
      .ROM_ADDR_WIDTH (21)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_rom_address (rsp_rom_address),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic logic [14:0] ram_slot(logic [15:0] addr);
      return {sel[1:0], addr[12:0]} & cfg_ram_mask;
   endfunction

   function automatic bit rtc_selected();
      return sel >= SEL_RTC_SEC && sel <= SEL_RTC_DAY_HIGH;
   endfunction

   function automatic bit ram_read_unwritten(logic [15:0] addr);
      return ram_enabled && !rtc_selected() && cfg_ram_banks != 3'd0
         && !ram_known[ram_slot(addr)];
   endfunction

   // one bus access: update the shadow state and return what the block answers
   function automatic bus_result_type map_access(op_type op, logic [15:0] addr,
                                                 logic [7:0] data);
      bus_result_type res;
      logic [14:0]    slot;
      logic [7:0]     bank;
      res = '0;
      slot = ram_slot(addr);
      case (op)
         OP_ROM_READ: begin
            res.rom_address = {7'd0, addr[13:0]};
            if (addr[15:14] == 2'b01) res.rom_address[20:14] = rom_bank;
            res.rom_address &= cfg_rom_mask;
         end
         OP_CTRL_WRITE: begin
            case (addr[15:13])
               REGION_ENABLE: ram_enabled = (data[3:0] == ENABLE_KEY);
               REGION_ROM_BANK: begin
                  bank = {1'b0, data[6:0]};
                  if (bank == 8'd0) begin
                     rom_bank = 7'd1;
                  end else begin
                     bank &= cfg_rom_banks - 8'd1;
                     rom_bank = bank[6:0];
                  end
               end
               REGION_SELECT: begin
                  if (data >= SEL_RTC_SEC && data <= SEL_RTC_DAY_HIGH) sel = data[3:0];
                  else sel = {2'b00, data[1:0]};
               end
               default: ;
            endcase
         end
         OP_RAM_READ: begin
            if (!ram_enabled) begin
               res.read_data = READ_DISABLED;
            end else if (rtc_selected()) begin
               case (sel)
                  SEL_RTC_SEC:     res.read_data = rtc_sec;
                  SEL_RTC_MIN:     res.read_data = rtc_min;
                  SEL_RTC_HOUR:    res.read_data = rtc_hour;
                  SEL_RTC_DAY_LOW: res.read_data = rtc_day_low;
                  default:         res.read_data = rtc_day_high;
               endcase
            end else if (cfg_ram_banks == 3'd0) begin
               res.read_data = READ_DISABLED;
            end else begin
               res.read_data = ram_shadow[slot];
            end
         end
         default: begin
            if (ram_enabled && rtc_selected()) begin
               case (sel)
                  SEL_RTC_SEC:     if (data < SECONDS_LIMIT) rtc_sec = data;
                  SEL_RTC_MIN:     if (data < SECONDS_LIMIT) rtc_min = data;
                  SEL_RTC_HOUR:    if (data < HOURS_LIMIT) rtc_hour = data;
                  SEL_RTC_DAY_LOW: rtc_day_low = data;
                  default:         rtc_day_high = data & DAY_HIGH_MASK;
               endcase
            end else if (ram_enabled && cfg_ram_banks != 3'd0) begin
               ram_shadow[slot] = data;
               ram_known[slot] = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   // results are checked before the item of the same edge is predicted
   always @(posedge clock) begin : scoreboard
      bus_result_type got;
      bus_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_read_data, rsp_rom_address};
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: read_data %02h rom_address %06h",
                     got.read_data, got.rom_address);
            end else begin
               want = expected_results.pop_front();
               if (got.read_data !== want.read_data || got.rom_address !== want.rom_address) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d: exp rd %02h ra %06h, got rd %02h ra %06h",
                        results_seen, want.read_data, want.rom_address,
                        got.read_data, got.rom_address);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = map_access(req_operation, req_address, req_write_data);
            if (pin_valid) want = pin_result;
            expected_results.push_back(want);
         end
      end
   end

   task automatic pick_random_item(inout stim_row_type row);
      int unsigned pick;
      int unsigned kind;
      pick = $urandom_range(0, 99);
      row = '0;
      row.kind = ROW_ITEM;
      row.data = 21'($urandom_range(0, 255));
      if (pick < 28) begin
         row.op = OP_ROM_READ;
         row.addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {2'b01, 14'($urandom)};
      end else if (pick < 50) begin
         row.op = OP_CTRL_WRITE;
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            row.addr = 16'($urandom_range(16'h0000, 16'h1FFF));
            if ($urandom_range(0, 3) != 0) row.data[3:0] = ENABLE_KEY;
         end else if (kind < 6) begin
            row.addr = 16'($urandom_range(16'h2000, 16'h3FFF));
            if ($urandom_range(0, 7) == 0) row.data[6:0] = '0;
         end else if (kind < 9) begin
            row.addr = 16'($urandom_range(16'h4000, 16'h5FFF));
            if ($urandom_range(0, 1) == 0)
               row.data = 21'($urandom_range(SEL_RTC_SEC, SEL_RTC_DAY_HIGH));
         end else begin
            row.addr = 16'($urandom_range(16'h6000, 16'hFFFF));
         end
      end else if (pick < 78) begin
         row.op = OP_RAM_READ;
         if (ram_addr_history.size() != 0 && $urandom_range(0, 4) != 0)
            row.addr = ram_addr_history[$urandom_range(0, ram_addr_history.size() - 1)];
         else
            row.addr = 16'($urandom);
      end else begin
         row.op = OP_RAM_WRITE;
         row.addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {3'b101, 13'($urandom)};
         // small values so rtc writes often pass their limits
         if ($urandom_range(0, 1) == 0) row.data = 21'($urandom_range(0, 63));
      end
      // never read a ram byte that has not been written
      if (row.op == OP_RAM_READ && ram_read_unwritten(row.addr)) row.op = OP_RAM_WRITE;
      if (row.op == OP_RAM_WRITE) begin
         ram_addr_history.push_back(row.addr);
         if (ram_addr_history.size() > 64) void'(ram_addr_history.pop_front());
      end
   endtask

   task automatic offer_item(input bit fresh, input stim_row_type row);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (fresh) pick_random_item(row);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= row.op;
      req_address <= row.addr;
      req_write_data <= row.data[7:0];
      pin_valid <= row.pinned;
      pin_result <= {row.exp_rd, row.exp_ra};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [20:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ROM_BANK_COUNT:   cfg_rom_banks = value[7:0];
         CSR_ROM_ADDRESS_MASK: cfg_rom_mask = value;
         CSR_RAM_BANK_COUNT:   cfg_ram_banks = value[2:0];
         CSR_RAM_ADDRESS_MASK: cfg_ram_mask = value[14:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: random stalls per item, plus a long hold on request
   initial begin : result_sink
      int stall_cycles;
      wait (!reset);
      forever begin
         if (hold_len > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         stall_cycles = receiver_calm ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      cfg_rom_banks = RESET_ROM_BANK_COUNT;
      cfg_rom_mask = RESET_ROM_ADDRESS_MASK;
      cfg_ram_banks = RESET_RAM_BANK_COUNT;
      cfg_ram_mask = RESET_RAM_ADDRESS_MASK;
      rom_bank = 7'd1;
      sel = '0;
      ram_enabled = 1'b0;
      {rtc_sec, rtc_min, rtc_hour, rtc_day_low, rtc_day_high} = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(DIRECTED[i].reg_idx, DIRECTED[i].data);
         end else begin
            offer_item(1'b0, DIRECTED[i]);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         wait_drained();
         write_csr(CSR_ROM_BANK_COUNT, 21'(PHASE_CFG[p].rom_banks));
         write_csr(CSR_ROM_ADDRESS_MASK, PHASE_CFG[p].rom_mask);
         write_csr(CSR_RAM_BANK_COUNT, 21'(PHASE_CFG[p].ram_banks));
         write_csr(CSR_RAM_ADDRESS_MASK, 21'(PHASE_CFG[p].ram_mask));
         sender_eager = (p % 3 == 1);
         receiver_calm = (p % 3 == 2);
         // receiver backs off while the sender keeps going, so the pipe fills up
         if (p == PRESSURE_PHASE) hold_len = HOLD_CYCLES;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) offer_item(1'b1, '0);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("ran %0d bus accesses and checked %0d results across %0d register writes",
         items_sent, results_seen, csr_writes);
      $display("including rom, control, ram and rtc accesses under %0d configurations",
         N_PHASES + 2);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
